>>> rtl/pid_controller_step_macros.svh
// Assertion macros for the PID step RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef PID_CONTROLLER_STEP_MACROS_SVH
`define PID_CONTROLLER_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pidc_pkg.sv
// Shared types and constants of the PID step block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pidc_pkg;

	// Field and internal word widths (Q16.16 based).
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned REG_W     = 31;
	localparam int unsigned ERR_W     = 33;
	localparam int unsigned DIFF_W    = 34;
	localparam int unsigned SUM_W     = 48;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned CHUNK_W   = 16;
	localparam int unsigned PROD_W    = DATA_W + SUM_W;
	localparam int unsigned TERM_W    = 62;
	localparam int unsigned TOTAL_W   = 64;
	localparam int unsigned QUO_W     = DIFF_W + FRAC_W;
	localparam int unsigned CFG_IDX_W = 3;

	// Sequencing of the shared units.
	localparam int unsigned MUL_STEPS     = SUM_W / CHUNK_W;
	localparam int unsigned MUL_CNT_W     = 2;
	localparam int unsigned DIV_STEPS     = QUO_W / 2;
	localparam int unsigned DIV_CNT_W     = 5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd4;

	// Reset value of the sample period: 1.0 in Q16.16.
	localparam logic [REG_W-1:0] PERIOD_RESET = 31'd65536;

	// Saturation bounds.
	localparam logic signed [SUM_W-1:0]   SUM_MAX   = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0]   SUM_MIN   = 48'sh8000_0000_0000;
	localparam logic signed [TOTAL_W-1:0] SUM_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [TOTAL_W-1:0] SUM_MIN64 = 64'shFFFF_8000_0000_0000;
	localparam logic [TERM_W-2:0]         TERM_MAX  = '1;

	// Operand pair fed to the shared multiplier.
	typedef enum logic [1:0] {
		SEL_ERR_DT = 2'd0,
		SEL_KP     = 2'd1,
		SEL_KI     = 2'd2,
		SEL_KD     = 2'd3
	} mul_sel_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic     capture;
		logic     load_diff;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     div_start;
		logic     sum_update;
		logic     acc_clear;
		logic     acc_add;
		logic     finish;
	} pidc_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic mul_done;
		logic div_busy;
	} pidc_stat_t;

endpackage

`default_nettype wire

>>> rtl/pidc_mul.sv
// Sequential signed fixed-point multiplier: (a*b) >> 16 by magnitude, saturated.
// Depends on pidc_pkg and pid_controller_step_macros.svh.
`default_nettype none
`include "pid_controller_step_macros.svh"

module pidc_mul import pidc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [DATA_W-1:0] a,
	input  wire logic signed [SUM_W-1:0]  b,
	output logic                          done,
	output logic signed [TERM_W-1:0]      result
);

	logic [DATA_W-1:0]           ma_q;
	logic [SUM_W-1:0]            mb_q;
	logic                        neg_q;
	logic [PROD_W-1:0]           acc_q;
	logic [MUL_CNT_W-1:0]        cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic signed [TERM_W-1:0]    res_q;

	logic [DATA_W-1:0]           ma_d;
	logic [SUM_W-1:0]            mb_d;
	logic [DATA_W+CHUNK_W-1:0]   pp;
	logic [PROD_W-1:0]           acc_d;
	logic [PROD_W-FRAC_W-1:0]    shifted;
	logic [TERM_W-2:0]           mag;
	logic signed [TERM_W-1:0]    res_d;
	logic                        last_step;

	// Operand magnitudes at start.
	assign ma_d = a[DATA_W-1] ? $unsigned(-a) : $unsigned(a);
	assign mb_d = b[SUM_W-1] ? $unsigned(-b) : $unsigned(b);

	// One 16-bit chunk of b per pass, most significant chunk first.
	assign pp    = ma_q * mb_q[SUM_W-1 -: CHUNK_W];
	assign acc_d = {acc_q[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + PROD_W'(pp);

	// Drop the fraction, saturate the magnitude, then apply the sign.
	assign shifted = acc_q[PROD_W-1:FRAC_W];
	assign mag     = (|shifted[PROD_W-FRAC_W-1:TERM_W-1]) ? TERM_MAX : shifted[TERM_W-2:0];
	assign res_d   = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

	assign last_step = (cnt_q == MUL_CNT_W'(MUL_STEPS));

	// Control: pass counter, busy and done flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Operands, accumulator and result.
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= ma_d;
			mb_q  <= mb_d;
			neg_q <= a[DATA_W-1] ^ b[SUM_W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			if (last_step) begin
				res_q <= res_d;
			end else begin
				acc_q <= acc_d;
				mb_q  <= mb_q << CHUNK_W;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`PIDC_ASSERT_NOW(a_mul_no_overlap, start, !busy_q, "multiply started while one is running")

endmodule

`default_nettype wire

>>> rtl/pidc_div.sv
// Restoring divider for the derivative: (|diff| << 16) / dt, two quotient bits a cycle.
// Depends on pidc_pkg and pid_controller_step_macros.svh.
`default_nettype none
`include "pid_controller_step_macros.svh"

module pidc_div import pidc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [DIFF_W-1:0] diff,
	input  wire logic [REG_W-1:0]         divisor,
	output logic                          busy,
	output logic signed [SUM_W-1:0]       deriv
);

	logic [REG_W-1:0]         d_q;
	logic [REG_W-1:0]         rem_q;
	logic [QUO_W-1:0]         quo_q;
	logic                     neg_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic                     busy_q;
	logic signed [SUM_W-1:0]  deriv_q;

	logic [DIFF_W-1:0]        mag;
	logic [REG_W:0]           t1, s1, t2, s2;
	logic                     ge1, ge2;
	logic [REG_W-1:0]         r1, r2;
	logic                     neg_big, pos_big;
	logic signed [SUM_W-1:0]  deriv_d;
	logic                     last_step;

	assign mag = diff[DIFF_W-1] ? $unsigned(-diff) : $unsigned(diff);

	// Two dependent restoring steps per cycle.
	always_comb begin
		t1  = {rem_q, quo_q[QUO_W-1]};
		s1  = t1 - {1'b0, d_q};
		ge1 = (t1 >= {1'b0, d_q});
		r1  = ge1 ? s1[REG_W-1:0] : t1[REG_W-1:0];
		t2  = {r1, quo_q[QUO_W-2]};
		s2  = t2 - {1'b0, d_q};
		ge2 = (t2 >= {1'b0, d_q});
		r2  = ge2 ? s2[REG_W-1:0] : t2[REG_W-1:0];
	end

	// Saturate the signed quotient to the 48-bit range.
	assign neg_big = (|quo_q[QUO_W-1:SUM_W]) || (quo_q[SUM_W-1] && (|quo_q[SUM_W-2:0]));
	assign pos_big = |quo_q[QUO_W-1:SUM_W-1];
	assign deriv_d = neg_q ? (neg_big ? SUM_MIN : -$signed(quo_q[SUM_W-1:0]))
	                       : (pos_big ? SUM_MAX : $signed(quo_q[SUM_W-1:0]));

	assign last_step = (cnt_q == DIV_CNT_W'(DIV_STEPS));

	// Control: iteration counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (last_step) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Partial remainder, quotient shift register and final result.
	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= divisor;
			rem_q <= '0;
			quo_q <= {mag, {FRAC_W{1'b0}}};
			neg_q <= diff[DIFF_W-1];
		end else if (busy_q) begin
			if (last_step) begin
				deriv_q <= deriv_d;
			end else begin
				rem_q <= r2;
				quo_q <= {quo_q[QUO_W-3:0], ge1, ge2};
			end
		end
	end

	assign busy  = busy_q;
	assign deriv = deriv_q;

	`PIDC_ASSERT_NOW(a_div_no_overlap, start, !busy_q, "divide started while one is running")

endmodule

`default_nettype wire

>>> rtl/pidc_dp.sv
// Datapath of the PID step: configuration, error, integral, gain sum and clamp.
// Depends on pidc_pkg, pidc_mul and pidc_div.
`default_nettype none

module pidc_dp import pidc_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [DATA_W-1:0]           cfg_data,
	input  wire logic signed [DATA_W-1:0]    target_value,
	input  wire logic signed [DATA_W-1:0]    measurement,
	input  wire pidc_cmd_t                   cmd,
	output pidc_stat_t                       stat,
	output logic [REG_W-1:0]                 drive
);

	logic signed [DATA_W-1:0]  kp_q, ki_q, kd_q;
	logic [REG_W-1:0]          limit_q, period_q;
	logic signed [SUM_W-1:0]   error_sum_q;
	logic signed [ERR_W-1:0]   last_error_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [TOTAL_W-1:0] total_q;
	logic [REG_W-1:0]          drive_q;

	logic [REG_W-1:0]          dt_eff;
	logic signed [SUM_W-1:0]   err_ext;
	logic signed [DATA_W-1:0]  mul_a;
	logic signed [SUM_W-1:0]   mul_b;
	logic                      mul_done;
	logic signed [TERM_W-1:0]  mul_res;
	logic                      div_busy;
	logic signed [SUM_W-1:0]   deriv;
	logic signed [TOTAL_W-1:0] sum_wide;
	logic signed [SUM_W-1:0]   sum_sat;
	logic [REG_W-1:0]          drive_d;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= '0;
			ki_q     <= '0;
			kd_q     <= '0;
			limit_q  <= '0;
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KP:     kp_q     <= $signed(cfg_data);
				REG_KI:     ki_q     <= $signed(cfg_data);
				REG_KD:     kd_q     <= $signed(cfg_data);
				REG_LIMIT:  limit_q  <= cfg_data[REG_W-1:0];
				REG_PERIOD: period_q <= cfg_data[REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A zero period counts as one LSB.
	assign dt_eff  = (period_q == '0) ? REG_W'(1) : period_q;
	assign err_ext = SUM_W'(err_q);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.mul_sel)
			SEL_ERR_DT: begin
				mul_a = $signed({1'b0, dt_eff});
				mul_b = err_ext;
			end
			SEL_KP: begin
				mul_a = kp_q;
				mul_b = err_ext;
			end
			SEL_KI: begin
				mul_a = ki_q;
				mul_b = error_sum_q;
			end
			SEL_KD: begin
				mul_a = kd_q;
				mul_b = deriv;
			end
			default: begin
				mul_a = $signed({1'b0, dt_eff});
				mul_b = err_ext;
			end
		endcase
	end

	pidc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	pidc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.diff    (diff_q),
		.divisor (dt_eff),
		.busy    (div_busy),
		.deriv   (deriv)
	);

	// Integral update with 48-bit saturation.
	assign sum_wide = TOTAL_W'(error_sum_q) + TOTAL_W'(mul_res);
	always_comb begin
		if (sum_wide > SUM_MAX64) begin
			sum_sat = SUM_MAX;
		end else if (sum_wide < SUM_MIN64) begin
			sum_sat = SUM_MIN;
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	// Clamp of the gain sum to zero and the drive limit.
	always_comb begin
		if (total_q[TOTAL_W-1]) begin
			drive_d = '0;
		end else if (total_q[TOTAL_W-2:0] > (TOTAL_W-1)'(limit_q)) begin
			drive_d = limit_q;
		end else begin
			drive_d = total_q[REG_W-1:0];
		end
	end

	// Controller state kept across items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else begin
			if (cmd.sum_update) begin
				error_sum_q <= sum_sat;
			end
			if (cmd.finish) begin
				last_error_q <= err_q;
			end
		end
	end

	// Per-item working registers and the output register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			err_q <= ERR_W'(target_value) - ERR_W'(measurement);
		end
		if (cmd.load_diff) begin
			diff_q <= DIFF_W'(err_q) - DIFF_W'(last_error_q);
		end
		if (cmd.acc_clear) begin
			total_q <= '0;
		end else if (cmd.acc_add) begin
			total_q <= total_q + TOTAL_W'(mul_res);
		end
		if (cmd.finish) begin
			drive_q <= drive_d;
		end
	end

	assign stat.mul_done = mul_done;
	assign stat.div_busy = div_busy;
	assign drive         = drive_q;

endmodule

`default_nettype wire

>>> rtl/pidc_ctrl.sv
// Sequencer of the PID step: issues datapath commands and owns both handshakes.
// Depends on pidc_pkg and pid_controller_step_macros.svh.
`default_nettype none
`include "pid_controller_step_macros.svh"

module pidc_ctrl import pidc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire pidc_stat_t stat,
	output pidc_cmd_t       cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DIFF     = 9'b000000010,
		S_DIV_GO   = 9'b000000100,
		S_INTEG    = 9'b000001000,
		S_PROP_W   = 9'b000010000,
		S_IGAIN_W  = 9'b000100000,
		S_DGAIN_GO = 9'b001000000,
		S_DGAIN_W  = 9'b010000000,
		S_FINISH   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.load_diff = 1'b1;
				cmd.acc_clear = 1'b1;
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = SEL_ERR_DT;
				state_d       = S_DIV_GO;
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_INTEG;
			end
			S_INTEG: begin
				if (stat.mul_done) begin
					cmd.sum_update = 1'b1;
					cmd.mul_start  = 1'b1;
					cmd.mul_sel    = SEL_KP;
					state_d        = S_PROP_W;
				end
			end
			S_PROP_W: begin
				if (stat.mul_done) begin
					cmd.acc_add   = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = SEL_KI;
					state_d       = S_IGAIN_W;
				end
			end
			S_IGAIN_W: begin
				if (stat.mul_done) begin
					cmd.acc_add = 1'b1;
					state_d     = S_DGAIN_GO;
				end
			end
			S_DGAIN_GO: begin
				if (!stat.div_busy) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = SEL_KD;
					state_d       = S_DGAIN_W;
				end
			end
			S_DGAIN_W: begin
				if (stat.mul_done) begin
					cmd.acc_add = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	`PIDC_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready, "second transfer taken mid item")
	`PIDC_ASSERT_NOW(a_idle_div_quiet, state_q == S_IDLE, !stat.div_busy, "divider busy while idle")
	`PIDC_ASSERT_NOW(a_idle_mul_quiet, state_q == S_IDLE, !stat.mul_done, "multiply result lost")

endmodule

`default_nettype wire

>>> rtl/pid_controller_step.sv
// PID controller step with output clamp, signed Q16.16. Each input transfer brings a setpoint
// and a measurement; the block updates a saturating 48-bit integral and the derivative, and
// returns one drive value clamped to zero..drive_limit. The time from an item's transfer until
// the next input can be taken, with the result then in the output register, is set by the
// derivative divider (50 quotient bits at two per cycle) followed by the final derivative-gain
// multiply, each multiply being three 32x16 passes plus a final saturate-and-sign step on one
// shared multiplier. The output register frees the input side while a result waits.
// Configuration writes are taken at any time (cfg_ready is always high) and must only be issued
// while no item is in flight. Depends on pidc_pkg, pidc_ctrl and pidc_dp.
`default_nettype none

module pid_controller_step import pidc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [DATA_W-1:0] target_value,
	input  wire logic signed [DATA_W-1:0] measurement,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [REG_W-1:0]              drive,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [DATA_W-1:0]        cfg_data
);

	pidc_cmd_t  cmd;
	pidc_stat_t stat;
	logic       cfg_we;

	// Register writes complete in the cycle they are offered.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	pidc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pidc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.target_value (target_value),
		.measurement  (measurement),
		.cmd          (cmd),
		.stat         (stat),
		.drive        (drive)
	);

endmodule

`default_nettype wire
